/* src/rit_pkg.sv */
// Shared types and constants for the repeating interval timer.
// Holds the item structs, command codes, status codes and the
// controller-to-datapath command and status bundles. No dependencies.
package rit_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_CNT_W = 5;

  // Command codes carried by an input item.
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

  // Status codes reported with each result item.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_IDLE     = 2'd1;
  localparam logic [ST_W-1:0] ST_REANCHOR = 2'd2;
  localparam logic [ST_W-1:0] ST_DONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] now_time;
    logic              fire_callback;
  } rit_in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             run_fired;
    logic [CNT_W-1:0] run_count;
    logic             over_fired;
    logic [CNT_W-1:0] count_now;
    logic             is_running;
  } rit_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic div_init;
    logic div_step;
    logic apply;
  } rit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
  } rit_stat_t;

endpackage

/* src/rit_dp.sv */
// Datapath of the repeating interval timer: configuration and timer state,
// the captured item, a bit-serial restoring divider and the result register.
// Depends on rit_pkg.
module rit_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rit_pkg::CNT_W-1:0]     cfg_wdata,
  input  rit_pkg::rit_in_t              in_data,
  input  rit_pkg::rit_cmd_t             cmd,
  output rit_pkg::rit_stat_t            stat,
  output rit_pkg::rit_out_t             out_data
);
  import rit_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] interval_r;
  logic [CNT_W-1:0] limit_r;

  // Timer state.
  logic              running_r, running_nxt;
  logic              paused_r, paused_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] anchor_r, anchor_nxt;

  // Captured item and evaluation results.
  rit_in_t           item_r;
  logic              rewound_r;
  logic              under_r;
  // Set when the decision cycle found at least one whole interval passed.
  logic              fire_r;

  // Divider: quotient shifts in from the dividend held in the same register.
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    trial;

  rit_out_t          out_r, res;
  logic [CNT_W-1:0]  iv;
  logic [CNT_W-1:0]  delta;
  logic [CNT_W:0]    sum;

  // An interval of zero behaves as an interval of one.
  assign iv = (interval_r == '0) ? CNT_W'(1) : interval_r;

  // Elapsed time is the low word of the difference to the anchor.
  assign delta = CNT_W'(item_r.now_time - anchor_r);

  // After evaluation quo_r holds the elapsed time until the divide starts.
  assign stat.need_div = (item_r.operation == OP_UPDATE) && running_r && !paused_r &&
                         !rewound_r && under_r && (quo_r >= iv);

  // One restoring divide step.
  always_comb begin
    trial   = {rem_r, quo_r[CNT_W-1]} - {1'b0, iv};
    rem_nxt = trial[CNT_W] ? {rem_r[CNT_W-2:0], quo_r[CNT_W-1]} : trial[CNT_W-1:0];
    quo_nxt = {quo_r[CNT_W-2:0], ~trial[CNT_W]};
  end

  assign sum = {1'b0, count_r} + {1'b0, quo_r};

  // Next timer state and the result of the current item.
  always_comb begin
    running_nxt    = running_r;
    paused_nxt     = paused_r;
    count_nxt      = count_r;
    anchor_nxt     = anchor_r;
    res.status     = ST_OK;
    res.run_fired  = 1'b0;
    res.run_count  = '0;
    res.over_fired = 1'b0;
    case (item_r.operation)
      OP_UPDATE: begin
        if (!running_r) begin
          res.status = ST_IDLE;
        end else if (paused_r || rewound_r) begin
          anchor_nxt = item_r.now_time;
          res.status = ST_REANCHOR;
        end else if (under_r) begin
          if (fire_r) begin
            count_nxt     = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
            anchor_nxt    = item_r.now_time;
            res.run_fired = 1'b1;
            res.run_count = quo_r;
          end
        end else begin
          running_nxt    = 1'b0;
          paused_nxt     = 1'b1;
          res.over_fired = 1'b1;
          res.status     = ST_DONE;
        end
      end
      OP_START: begin
        if (!running_r) begin
          running_nxt = 1'b1;
          paused_nxt  = 1'b0;
          count_nxt   = '0;
          anchor_nxt  = item_r.now_time;
          if (item_r.fire_callback) begin
            res.run_fired = 1'b1;
            res.run_count = CNT_W'(1);
          end
        end
      end
      OP_STOP: begin
        if (running_r) begin
          running_nxt    = 1'b0;
          paused_nxt     = 1'b1;
          res.over_fired = item_r.fire_callback;
        end
      end
      OP_PAUSE:  paused_nxt = 1'b1;
      OP_RESUME: paused_nxt = 1'b0;
      default: ;
    endcase
    res.count_now  = count_nxt;
    res.is_running = running_nxt;
  end

  // Configuration and timer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= CNT_W'(1);
      limit_r    <= '0;
      running_r  <= 1'b0;
      paused_r   <= 1'b0;
      count_r    <= '0;
      anchor_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_wdata;
          CFG_LIMIT:    limit_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.apply) begin
        running_r <= running_nxt;
        paused_r  <= paused_nxt;
        count_r   <= count_nxt;
        anchor_r  <= anchor_nxt;
      end
    end
  end

  // Item capture, evaluation, divider and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.eval) begin
      rewound_r <= item_r.now_time < anchor_r;
      under_r   <= (limit_r == '0) || (count_r < limit_r);
      quo_r     <= delta;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      fire_r <= stat.need_div;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.apply) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

/* src/rit_ctrl.sv */
// Controller of the repeating interval timer: sequences capture, evaluation,
// the serial divide and the commit, and owns both handshakes.
// Depends on rit_pkg.
module rit_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rit_pkg::rit_stat_t stat,
  output rit_pkg::rit_cmd_t  cmd
);
  import rit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_DIV,
    S_APPLY
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 div_last;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign div_last = (div_cnt_r == '1);

  // Command decode and next state.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = stat.need_div ? S_DIV : S_APPLY;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // An accepted item always moves on to evaluation.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EVAL))
    else $error("accepted item did not enter evaluation");

  // A new result appears only from a commit.
  a_rise_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result valid raised outside commit");

  // The divide ends after its last step and goes to commit.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_last) |=> (state_r == S_APPLY))
    else $error("divide did not end in commit");

  // A waiting result is never overwritten by a commit.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || !out_stall))
    else $error("commit while result still waits");
`endif

endmodule

/* src/repeating_interval_timer.sv */
// Top level of the repeating interval timer: controller plus datapath.
// Depends on rit_pkg, rit_ctrl and rit_dp.
//
// One item is processed at a time. An update that fires a run goes through
// capture, evaluation, decision, 32 steps of the bit-serial restoring divider
// that splits elapsed time into whole intervals, and a commit. Every other
// item skips the divide. The result register lets a new item be accepted while
// the previous result still waits to be taken; a commit waits only when that
// register is still full. Configuration is written through cfg_we, cfg_index and
// cfg_wdata, by the user only while idle; the block does not enforce this.
module repeating_interval_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rit_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rit_pkg::rit_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rit_pkg::rit_out_t             out_data
);
  import rit_pkg::*;

  rit_cmd_t  cmd;
  rit_stat_t stat;

  rit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for repeating_interval_timer: directed and random
// command streams, checked against an in-bench model of the timer.
// Depends on rit_pkg and the repeating_interval_timer RTL only.
module tb;
  import rit_pkg::*;

  // Command codes the block does not define; it must ignore them.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Length of the receiver's long hold-off, in cycles.
  localparam int LONG_HOLD_CYCLES = 400;
  // Cycles to let pass after the last result before touching configuration.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 40;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  rit_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rit_out_t out_data;

  repeating_interval_timer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copies of the registers and of the timer state.
  logic [CNT_W-1:0] reg_interval = 32'd1;
  logic [CNT_W-1:0] reg_limit = 32'd0;
  logic tm_running = 1'b0;
  logic tm_paused = 1'b0;
  logic [CNT_W-1:0] tm_count = '0;
  logic [TIME_W-1:0] tm_anchor = '0;

  rit_in_t cmd_queue[$];
  rit_out_t due_reports[$];
  int err_count = 0;
  int result_index = 0;

  // Driver and receiver pacing, set per phase.
  int send_style = 0;
  int recv_style = 0;
  bit send_hold = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_wait = 0;
  bit drv_busy = 1'b0;
  rit_in_t drv_item = '0;

  // Running timestamp of the random command stream.
  logic [TIME_W-1:0] gen_clock = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(12 * 1000000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Idle cycles before the next item: none, a uniform draw, or mostly none.
  function automatic int draw_gap(int style);
    if (style == 0) return 0;
    if (style == 1) return $urandom_range(0, 17);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
  endfunction

  // Advances the timer model by one command and returns the result it yields.
  function automatic rit_out_t timer_next(rit_in_t cmd);
    rit_out_t res;
    logic [CNT_W-1:0] delta;
    logic [CNT_W-1:0] eff_iv;
    logic [CNT_W-1:0] whole;
    logic [CNT_W-1:0] sum;
    res = '0;
    res.status = ST_OK;
    case (cmd.operation)
      OP_UPDATE: begin
        if (!tm_running) begin
          res.status = ST_IDLE;
        end else if (tm_paused || cmd.now_time < tm_anchor) begin
          tm_anchor = cmd.now_time;
          res.status = ST_REANCHOR;
        end else if (reg_limit == 0 || tm_count < reg_limit) begin
          // Elapsed time wraps at 32 bits; a zero interval counts as one.
          delta = cmd.now_time[CNT_W-1:0] - tm_anchor[CNT_W-1:0];
          eff_iv = (reg_interval == 0) ? 32'd1 : reg_interval;
          if (delta >= eff_iv) begin
            whole = delta / eff_iv;
            sum = tm_count + whole;
            if (sum < tm_count) sum = '1;
            tm_count = sum;
            tm_anchor = cmd.now_time;
            res.run_fired = 1'b1;
            res.run_count = whole;
          end
        end else begin
          // Limit reached: the timer stops itself and signals completion.
          tm_running = 1'b0;
          tm_paused = 1'b1;
          res.over_fired = 1'b1;
          res.status = ST_DONE;
        end
      end
      OP_START: begin
        if (!tm_running) begin
          tm_running = 1'b1;
          tm_paused = 1'b0;
          tm_count = '0;
          tm_anchor = cmd.now_time;
          if (cmd.fire_callback) begin
            res.run_fired = 1'b1;
            res.run_count = 32'd1;
          end
        end
      end
      OP_STOP: begin
        if (tm_running) begin
          tm_running = 1'b0;
          tm_paused = 1'b1;
          res.over_fired = cmd.fire_callback;
        end
      end
      OP_PAUSE: tm_paused = 1'b1;
      OP_RESUME: tm_paused = 1'b0;
      default: ;
    endcase
    res.count_now = tm_count;
    res.is_running = tm_running;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch in result %0d: %s got %0h, expected %0h",
               result_index, what, got, want);
  endtask

  task automatic check_result(rit_out_t got);
    rit_out_t want;
    if (due_reports.size() == 0) begin
      report_mismatch("unexpected result, status", 64'(got.status), 64'(0));
      return;
    end
    want = due_reports.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.run_fired !== want.run_fired)
      report_mismatch("run_fired", 64'(got.run_fired), 64'(want.run_fired));
    if (got.run_count !== want.run_count)
      report_mismatch("run_count", 64'(got.run_count), 64'(want.run_count));
    if (got.over_fired !== want.over_fired)
      report_mismatch("over_fired", 64'(got.over_fired), 64'(want.over_fired));
    if (got.count_now !== want.count_now)
      report_mismatch("count_now", 64'(got.count_now), 64'(want.count_now));
    if (got.is_running !== want.is_running)
      report_mismatch("is_running", 64'(got.is_running), 64'(want.is_running));
    result_index++;
  endtask

  // Driver: offers queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_reports.push_back(timer_next(in_data));
        drv_busy = 1'b0;
        send_gap = draw_gap(send_style);
      end
      if (!drv_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!send_hold && cmd_queue.size() != 0) begin
          drv_item = cmd_queue.pop_front();
          drv_busy = 1'b1;
        end
      end
      in_valid <= drv_busy;
      in_data <= drv_item;
    end
  end

  // Monitor: takes results, checks them and decides the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        recv_wait = draw_gap(recv_style);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_INTERVAL) reg_interval = val;
    else reg_limit = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_cmd(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp, logic fire);
    rit_in_t it;
    it.operation = op;
    it.now_time = stamp;
    it.fire_callback = fire;
    cmd_queue.push_back(it);
  endtask

  // Waits until every queued item has been taken and answered, then settles.
  task automatic drain();
    while (cmd_queue.size() != 0 || drv_busy || due_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed timer traffic on a moving clock, with some noise.
  function automatic rit_in_t random_cmd();
    rit_in_t it;
    logic [TIME_W-1:0] eff_iv;
    logic [TIME_W-1:0] step;
    int pick;
    eff_iv = (reg_interval == 0) ? 64'd1 : {32'd0, reg_interval};
    it.fire_callback = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.operation = OP_W'($urandom_range(0, 7));
      it.now_time = {$urandom, $urandom};
      return it;
    end
    case ($urandom_range(0, 4))
      0: step = {32'd0, $urandom} % (eff_iv / 2 + 1);
      1: step = eff_iv - 1 + $urandom_range(0, 2);
      2: step = {32'd0, $urandom} % (eff_iv * 4 + 1);
      3: step = {32'd0, $urandom};
      default: step = 64'h1_0000_0000 * $urandom_range(1, 3) + $urandom_range(0, 9);
    endcase
    it.now_time = gen_clock;
    if (pick < 16) begin
      it.operation = OP_START;
    end else if (pick < 20) begin
      it.operation = OP_STOP;
    end else if (pick < 24) begin
      it.operation = OP_PAUSE;
    end else if (pick < 28) begin
      it.operation = OP_RESUME;
    end else if (pick < 31) begin
      // Time running backwards relative to the anchor.
      it.operation = OP_UPDATE;
      it.now_time = gen_clock - $urandom_range(1, 50);
    end else begin
      it.operation = OP_UPDATE;
      gen_clock = gen_clock + step;
      it.now_time = gen_clock;
    end
    return it;
  endfunction

  task automatic run_phase(logic [CNT_W-1:0] iv, logic [CNT_W-1:0] lim, int count,
                           int s_style, int r_style, bit squeeze);
    write_reg(CFG_INTERVAL, iv);
    write_reg(CFG_LIMIT, lim);
    send_style = s_style;
    recv_style = r_style;
    gen_clock = {$urandom, $urandom} >> $urandom_range(0, 40);
    for (int i = 0; i < count; i++) cmd_queue.push_back(random_cmd());
    if (squeeze) begin
      // Receiver holds off while items keep coming, so the block backs up.
      hold_requests++;
      while (cmd_queue.size() > count / 2) @(negedge clk);
      // Sender then pauses until everything it sent has been answered.
      send_hold = 1'b1;
      while (drv_busy || due_reports.size() != 0) @(negedge clk);
      repeat ($urandom_range(5, 30)) @(negedge clk);
      send_hold = 1'b0;
    end
    drain();
  endtask

  initial begin
    @(posedge rst_n);
    @(negedge clk);

    // Directed: command corners with interval 5 and a limit of 3.
    write_reg(CFG_INTERVAL, 32'd5);
    write_reg(CFG_LIMIT, 32'd3);
    send_style = 2;
    recv_style = 2;
    queue_cmd(OP_UPDATE, 64'd0, 1'b0);
    queue_cmd(OP_STOP, 64'd0, 1'b1);
    queue_cmd(OP_PAUSE, 64'd0, 1'b0);
    queue_cmd(OP_RESUME, 64'd0, 1'b0);
    queue_cmd(OP_UNUSED_LO, '1, 1'b1);
    queue_cmd(OP_UNUSED_HI, 64'd0, 1'b0);
    queue_cmd(OP_START, 64'd100, 1'b1);
    queue_cmd(OP_START, 64'd200, 1'b1);
    queue_cmd(OP_UPDATE, 64'd103, 1'b0);
    queue_cmd(OP_UPDATE, 64'd112, 1'b1);
    queue_cmd(OP_UPDATE, 64'd50, 1'b0);
    queue_cmd(OP_PAUSE, 64'd0, 1'b0);
    queue_cmd(OP_UPDATE, 64'd60, 1'b0);
    queue_cmd(OP_RESUME, 64'd0, 1'b0);
    queue_cmd(OP_UPDATE, 64'd66, 1'b0);
    queue_cmd(OP_UPDATE, 64'd1000, 1'b0);
    queue_cmd(OP_UPDATE, 64'd2000, 1'b0);
    queue_cmd(OP_START, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    queue_cmd(OP_UPDATE, '1, 1'b0);
    queue_cmd(OP_STOP, 64'd0, 1'b1);
    queue_cmd(OP_START, 64'd0, 1'b0);
    queue_cmd(OP_STOP, 64'd0, 1'b0);
    drain();

    // Directed: elapsed time wrapping at 32 bits and count saturation.
    write_reg(CFG_INTERVAL, 32'd1);
    write_reg(CFG_LIMIT, 32'd0);
    queue_cmd(OP_START, 64'd0, 1'b0);
    queue_cmd(OP_UPDATE, 64'h1_0000_0007, 1'b0);
    queue_cmd(OP_UPDATE, 64'h2_0000_0006, 1'b0);
    drain();

    // Directed: a zero interval acts as one, then the widest interval.
    write_reg(CFG_INTERVAL, 32'd0);
    queue_cmd(OP_UPDATE, 64'h2_0000_0009, 1'b0);
    drain();
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    queue_cmd(OP_UPDATE, 64'h3_0000_0008, 1'b1);
    queue_cmd(OP_UPDATE, 64'h3_0000_0009, 1'b1);
    drain();

    // Random phases over a spread of register settings.
    run_phase(32'd1, 32'd0, 240, 1, 1, 1'b0);
    run_phase(32'd7, 32'd0, 240, 0, 0, 1'b0);
    run_phase(32'd100, 32'd5, 240, 2, 2, 1'b1);
    run_phase(32'd0, 32'd2, 240, 1, 0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd0, 240, 0, 1, 1'b0);
    run_phase($urandom_range(2, 50), $urandom_range(1, 20), 240, 2, 1, 1'b1);
    run_phase(32'd1000, 32'd1, 240, 1, 2, 1'b0);
    run_phase(32'h8000_0000, 32'hFFFF_FFFF, 240, 1, 1, 1'b0);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
